/* src/hcbd_pkg.sv */
// Shared types and constants for the chunked HTTP body decoder.
// Used by hcbd_step, hcbd_out_buf and http_chunked_body_decoder_unit.
`default_nettype none

package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START_WITH_HEADERS = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_BODY_BYTES = 8'd1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [2:0] {
    PH_HEADERS = 3'd0,
    PH_SIZE = 3'd1,
    PH_DATA = 3'd2,
    PH_END = 3'd3,
    PH_TRAILER = 3'd4,
    PH_FINISHED = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY = 3'd0,
    ST_DONE = 3'd1,
    ST_BAD_SIZE = 3'd2,
    ST_NO_CRLF = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_CLOSED = 3'd5
  } status_t;

  // size line flags
  typedef struct packed {
    logic cr;
    logic ext;
    logic tail;
    logic digit;
  } line_flags_t;

  // decoder state apart from the chunk counter, whose width is a parameter
  typedef struct packed {
    phase_t      phase;
    line_flags_t flags;
    logic [1:0]  term_match;
    logic [31:0] bytes_emitted;
    status_t     status;
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       close_event;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] body_length;
  } out_item_t;

  // hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/hcbd_step.sv */
// Next-state logic of the decoder: one input item against the registered state.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_step #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire hcbd_pkg::state_t   cur,
  input  wire [SIZE_BITS-1:0]     rem,
  input  wire [31:0]              max_body_bytes,
  input  wire hcbd_pkg::in_item_t item,
  output hcbd_pkg::state_t        nxt,
  output logic [SIZE_BITS-1:0]    rem_next,
  output hcbd_pkg::out_item_t     result
);

  logic [7:0] b;
  logic [4:0] hex;
  logic       valid;
  logic [SIZE_BITS-1:0] rem_dec;

  assign b = item.in_byte;
  assign hex = hcbd_pkg::hex_value(b);
  assign rem_dec = rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    nxt = cur;
    rem_next = rem;
    valid = 1'b0;
    if (cur.phase != hcbd_pkg::PH_FINISHED) begin
      if (item.close_event) begin
        nxt.phase = hcbd_pkg::PH_FINISHED;
        if (cur.phase == hcbd_pkg::PH_HEADERS || cur.phase == hcbd_pkg::PH_SIZE) begin
          nxt.status = hcbd_pkg::ST_CLOSED;
        end else begin
          nxt.status = hcbd_pkg::ST_DONE;
        end
      end else begin
        unique case (cur.phase)
          hcbd_pkg::PH_HEADERS: begin
            // pattern CR LF CR LF: even positions want CR, odd ones LF
            if (b == (cur.term_match[0] ? hcbd_pkg::CH_LF : hcbd_pkg::CH_CR)) begin
              if (cur.term_match == 2'd3) begin
                nxt.term_match = 2'd0;
                nxt.flags = '0;
                nxt.phase = hcbd_pkg::PH_SIZE;
              end else begin
                nxt.term_match = cur.term_match + 2'd1;
              end
            end else begin
              nxt.term_match = (b == hcbd_pkg::CH_CR) ? 2'd1 : 2'd0;
            end
          end
          hcbd_pkg::PH_SIZE: begin
            if (cur.flags.cr) begin
              if (b != hcbd_pkg::CH_LF || !cur.flags.digit) begin
                nxt.phase = hcbd_pkg::PH_FINISHED;
                nxt.status = hcbd_pkg::ST_BAD_SIZE;
              end else begin
                nxt.flags = '0;
                nxt.term_match = 2'd0;
                nxt.phase = (rem == '0) ? hcbd_pkg::PH_TRAILER : hcbd_pkg::PH_DATA;
              end
            end else if (b == hcbd_pkg::CH_CR) begin
              nxt.flags.cr = 1'b1;
            end else if (cur.flags.ext) begin
              nxt.flags = cur.flags;
            end else if (b == hcbd_pkg::CH_SEMI) begin
              nxt.flags.ext = 1'b1;
            end else if (b == hcbd_pkg::CH_SPACE || b == hcbd_pkg::CH_TAB) begin
              if (cur.flags.digit) begin
                nxt.flags.tail = 1'b1;
              end
            end else if (!hex[4] || cur.flags.tail || rem[SIZE_BITS-1 -: 4] != 4'd0) begin
              nxt.phase = hcbd_pkg::PH_FINISHED;
              nxt.status = hcbd_pkg::ST_BAD_SIZE;
            end else begin
              rem_next = {rem[SIZE_BITS-5:0], hex[3:0]};
              nxt.flags.digit = 1'b1;
            end
          end
          hcbd_pkg::PH_DATA: begin
            if (max_body_bytes != 32'd0 && cur.bytes_emitted >= max_body_bytes) begin
              nxt.phase = hcbd_pkg::PH_FINISHED;
              nxt.status = hcbd_pkg::ST_TOO_LARGE;
            end else begin
              valid = 1'b1;
              if (cur.bytes_emitted != 32'hFFFF_FFFF) begin
                nxt.bytes_emitted = cur.bytes_emitted + 32'd1;
              end
              rem_next = rem_dec;
              if (rem_dec == '0) begin
                nxt.phase = hcbd_pkg::PH_END;
                nxt.term_match = 2'd0;
              end
            end
          end
          hcbd_pkg::PH_END: begin
            if (cur.term_match == 2'd0 && b == hcbd_pkg::CH_CR) begin
              nxt.term_match = 2'd1;
            end else if (cur.term_match == 2'd1 && b == hcbd_pkg::CH_LF) begin
              nxt.term_match = 2'd0;
              nxt.flags = '0;
              rem_next = '0;
              nxt.phase = hcbd_pkg::PH_SIZE;
            end else begin
              nxt.phase = hcbd_pkg::PH_FINISHED;
              nxt.status = hcbd_pkg::ST_NO_CRLF;
            end
          end
          hcbd_pkg::PH_TRAILER: begin
            // 1: CR at line start, 2: inside a line, 3: CR inside a line
            if (b == hcbd_pkg::CH_LF && cur.term_match[0]) begin
              if (cur.term_match == 2'd1) begin
                nxt.phase = hcbd_pkg::PH_FINISHED;
                nxt.status = hcbd_pkg::ST_DONE;
              end else begin
                nxt.term_match = 2'd0;
              end
            end else if (b == hcbd_pkg::CH_CR) begin
              nxt.term_match = (cur.term_match == 2'd0) ? 2'd1 : 2'd3;
            end else begin
              nxt.term_match = 2'd2;
            end
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.payload_valid = valid;
    result.payload_byte = valid ? b : 8'd0;
    result.status = nxt.status;
    result.body_length = nxt.bytes_emitted;
  end

endmodule

`default_nettype wire

/* src/hcbd_out_buf.sv */
// Two-entry result queue that parts the output handshake from the decoder.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_out_buf (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  wire hcbd_pkg::out_item_t push_data,
  output logic                     not_full,
  output logic                     out_valid,
  input  wire                      out_ready,
  output hcbd_pkg::out_item_t      out_data
);

  hcbd_pkg::out_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign not_full = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data = entries[rd_ptr];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/http_chunked_body_decoder_unit.sv */
// Chunked HTTP body decoder, top level.
// Depends on hcbd_pkg, hcbd_step and hcbd_out_buf.
//
// Takes one byte of a chunked body per accepted item and gives one result item
// for each: a decoded payload byte when there is one, the status code and the
// running payload count. One item is accepted every clock while in_ready is
// high; its result is ready in the output queue in the cycle after acceptance.
// The rate is set by the decoder state loop, closed on the registered state.
// The two-entry output queue keeps input ready high while one result waits;
// in_ready falls only when both entries are held. Registers are written on the
// cfg channel, which is always ready; a write of start_with_headers before the
// first item after reset also selects the start phase.
`default_nettype none

module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire hcbd_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output hcbd_pkg::out_item_t                  out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [hcbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [hcbd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  hcbd_pkg::state_t    state;
  hcbd_pkg::state_t    state_next;
  hcbd_pkg::out_item_t result;
  logic [SIZE_BITS-1:0] chunk_remaining;
  logic [SIZE_BITS-1:0] chunk_remaining_next;
  logic [31:0] max_body_bytes;
  logic        untouched;
  logic        accept;
  logic        cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept = in_valid && in_ready;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .cur            (state),
    .rem            (chunk_remaining),
    .max_body_bytes (max_body_bytes),
    .item           (in_data),
    .nxt            (state_next),
    .rem_next       (chunk_remaining_next),
    .result         (result)
  );

  hcbd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .not_full  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // start_with_headers has no effect beyond the start phase, so only the phase
  // choice is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= 32'd0;
      untouched <= 1'b1;
      state <= '{phase: hcbd_pkg::PH_SIZE, flags: '0, term_match: 2'd0,
                 bytes_emitted: 32'd0, status: hcbd_pkg::ST_BUSY};
      chunk_remaining <= '0;
    end else begin
      if (accept) begin
        untouched <= 1'b0;
        state <= state_next;
        chunk_remaining <= chunk_remaining_next;
      end else if (cfg_write && cfg_index == hcbd_pkg::REG_START_WITH_HEADERS &&
                   untouched) begin
        state.phase <= cfg_data[0] ? hcbd_pkg::PH_HEADERS : hcbd_pkg::PH_SIZE;
      end
      if (cfg_write && cfg_index == hcbd_pkg::REG_MAX_BODY_BYTES) begin
        max_body_bytes <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_chunked_body_decoder_unit: a chunked body decoded byte by byte.
// Needs hcbd_pkg and the decoder RTL; predicts each result item in step with accepted input items.

module tb;
  import hcbd_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1500;

  typedef enum {
    END_TRAILER, END_CLOSE_LATE, END_BAD_SIZE, END_NO_CRLF, END_LIMIT, END_CLOSE_EARLY
  } finish_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       cl;
    logic       typed;
    out_item_t  want;
  } stim_row_t;

  localparam out_item_t NO_CHECK = '0;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  http_chunked_body_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // decoder state as predicted
  phase_t      ph = PH_SIZE;
  logic [SIZE_BITS_DEF-1:0] chunk_left = '0;
  logic [31:0] emitted = '0;
  line_flags_t flags = '0;
  logic [1:0]  tmatch = '0;
  status_t     kept = ST_BUSY;
  bit          fresh = 1'b1;
  bit          hdr_mode = 1'b0;
  logic [31:0] body_limit = '0;

  out_item_t awaited_out[$];
  int        mismatches = 0;
  int        n_items = 0;
  bit        calm = 1'b0;
  bit        long_hold = 1'b0;

  // header, blanks and extension, two chunks (the second holds a CR byte)
  stim_row_t script [24] = '{
    '{"H",      1'b0, 1'b1, '{1'b0, 8'h00, ST_BUSY, 32'd0}},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_LF,    1'b0, 1'b0, NO_CHECK},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_LF,    1'b0, 1'b0, NO_CHECK},
    '{CH_SPACE, 1'b0, 1'b0, NO_CHECK},
    '{"0",      1'b0, 1'b0, NO_CHECK},
    '{"2",      1'b0, 1'b0, NO_CHECK},
    '{CH_TAB,   1'b0, 1'b0, NO_CHECK},
    '{CH_SEMI,  1'b0, 1'b0, NO_CHECK},
    '{CH_SPACE, 1'b0, 1'b0, NO_CHECK},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_LF,    1'b0, 1'b0, NO_CHECK},
    '{8'h00,    1'b0, 1'b1, '{1'b1, 8'h00, ST_BUSY, 32'd1}},
    '{8'hFF,    1'b0, 1'b1, '{1'b1, 8'hFF, ST_BUSY, 32'd2}},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_LF,    1'b0, 1'b0, NO_CHECK},
    '{"1",      1'b0, 1'b0, NO_CHECK},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_LF,    1'b0, 1'b0, NO_CHECK},
    '{CH_CR,    1'b0, 1'b1, '{1'b1, 8'h0D, ST_BUSY, 32'd3}},
    '{CH_CR,    1'b0, 1'b0, NO_CHECK},
    '{CH_LF,    1'b0, 1'b0, NO_CHECK}
  };

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == x) b = ~x;
    return b;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned pick_chunk_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  function automatic void stop_with(input status_t code);
    ph = PH_FINISHED;
    kept = code;
  endfunction

  function automatic void header_char(input logic [7:0] b);
    logic [7:0] want;
    want = tmatch[0] ? CH_LF : CH_CR;
    if (b == want) begin
      if (tmatch == 2'd3) begin
        tmatch = '0;
        flags = '0;
        ph = PH_SIZE;
      end else begin
        tmatch = tmatch + 2'd1;
      end
    end else begin
      tmatch = (b == CH_CR) ? 2'd1 : 2'd0;
    end
  endfunction

  function automatic void size_char(input logic [7:0] b);
    int d;
    if (flags.cr) begin
      if (b != CH_LF || !flags.digit) begin
        stop_with(ST_BAD_SIZE);
      end else begin
        flags = '0;
        tmatch = '0;
        ph = (chunk_left == 0) ? PH_TRAILER : PH_DATA;
      end
    end else if (b == CH_CR) begin
      flags.cr = 1'b1;
    end else if (!flags.ext) begin
      if (b == CH_SEMI) begin
        flags.ext = 1'b1;
      end else if (b == CH_SPACE || b == CH_TAB) begin
        if (flags.digit) flags.tail = 1'b1;
      end else begin
        d = hex_digit(b);
        // no room for another digit once the top nibble is in use
        if (d < 0 || flags.tail || chunk_left[SIZE_BITS_DEF-1 -: 4] != 0) begin
          stop_with(ST_BAD_SIZE);
        end else begin
          chunk_left = {chunk_left[SIZE_BITS_DEF-5:0], 4'(d)};
          flags.digit = 1'b1;
        end
      end
    end
  endfunction

  function automatic void trailer_char(input logic [7:0] b);
    if (b == CH_LF && (tmatch == 2'd1 || tmatch == 2'd3)) begin
      if (tmatch == 2'd1) stop_with(ST_DONE);
      else tmatch = '0;
    end else if (b == CH_CR) begin
      tmatch = (tmatch == 2'd0) ? 2'd1 : 2'd3;
    end else begin
      tmatch = 2'd2;
    end
  endfunction

  function automatic out_item_t decode_byte(input in_item_t it);
    out_item_t r;
    logic [7:0] b;
    r = '0;
    b = it.in_byte;
    fresh = 1'b0;
    if (ph != PH_FINISHED) begin
      if (it.close_event) begin
        stop_with((ph == PH_HEADERS || ph == PH_SIZE) ? ST_CLOSED : ST_DONE);
      end else begin
        case (ph)
          PH_HEADERS: header_char(b);
          PH_SIZE: size_char(b);
          PH_DATA: begin
            if (body_limit != 0 && emitted >= body_limit) begin
              stop_with(ST_TOO_LARGE);
            end else begin
              r.payload_valid = 1'b1;
              r.payload_byte = b;
              if (emitted != '1) emitted = emitted + 1;
              chunk_left = chunk_left - 1;
              if (chunk_left == 0) begin
                ph = PH_END;
                tmatch = '0;
              end
            end
          end
          PH_END: begin
            if (tmatch == 2'd0 && b == CH_CR) begin
              tmatch = 2'd1;
            end else if (tmatch == 2'd1 && b == CH_LF) begin
              tmatch = '0;
              flags = '0;
              chunk_left = '0;
              ph = PH_SIZE;
            end else begin
              stop_with(ST_NO_CRLF);
            end
          end
          default: trailer_char(b);
        endcase
      end
    end
    r.status = kept;
    r.body_length = emitted;
    return r;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic cl, input bit typed = 1'b0,
                           input out_item_t want = '0);
    int gap;
    out_item_t guess;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, close_event: cl};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = decode_byte('{in_byte: b, close_event: cl});
    awaited_out.push_back(typed ? want : guess);
    n_items++;
    if (n_items == 300) long_hold = 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_START_WITH_HEADERS) begin
      hdr_mode = val[0];
      if (fresh) ph = hdr_mode ? PH_HEADERS : PH_SIZE;
    end else if (idx == REG_MAX_BODY_BYTES) begin
      body_limit = val;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_size_line(input logic [31:0] sz);
    int nd;
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    repeat ($urandom_range(0, 2)) send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) send_item("0", 1'b0);
    for (int i = nd - 1; i >= 0; i--) send_item(hex_char(sz[4*i +: 4], $urandom_range(0, 1)), 1'b0);
    repeat ($urandom_range(0, 2)) send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      send_item(CH_SEMI, 1'b0);
      repeat ($urandom_range(0, 5)) send_item(any_but(CH_CR), 1'b0);
    end
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  task automatic send_chunk(input int unsigned sz);
    send_size_line(sz);
    repeat (sz) send_item(8'($urandom), 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  always @(posedge clk) begin : check_out
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: valid=%0b byte=%02h status=%0d len=%0d",
                   out_data.payload_valid, out_data.payload_byte, out_data.status,
                   out_data.body_length);
      end else begin
        want = awaited_out.pop_front();
        if (out_data.payload_valid !== want.payload_valid ||
            out_data.payload_byte !== want.payload_byte ||
            out_data.status !== want.status ||
            out_data.body_length !== want.body_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp valid=%0b byte=%02h status=%0d len=%0d, got %0b %02h %0d %0d",
                     want.payload_valid, want.payload_byte, want.status, want.body_length,
                     out_data.payload_valid, out_data.payload_byte, out_data.status,
                     out_data.body_length);
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        // fill the output queue so the input side backs up
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL http_chunked_body_decoder_unit");
    $finish;
  end

  initial begin : stimulus
    int chunks;
    int unsigned spare;
    finish_kind_t how;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // start phase follows the last header-mode write before the first item
    write_reg(CFG_INDEX_BITS'($urandom_range(2, 255)), 32'($urandom));
    write_reg(REG_START_WITH_HEADERS, 32'd0);
    write_reg(REG_MAX_BODY_BYTES, 32'hFFFF_FFFF);
    write_reg(REG_START_WITH_HEADERS, 32'd1);
    foreach (script[i]) send_item(script[i].b, script[i].cl, script[i].typed, script[i].want);
    drain();
    write_reg(REG_MAX_BODY_BYTES, 32'd0);
    write_reg(REG_START_WITH_HEADERS, 32'd0);

    chunks = 0;
    while (n_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      send_chunk(pick_chunk_len());
      chunks++;
      if (chunks % 20 == 0) begin
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(REG_MAX_BODY_BYTES, 32'd0);
          1: write_reg(REG_MAX_BODY_BYTES, 32'hFFFF_FFFF);
          default: write_reg(REG_MAX_BODY_BYTES, emitted + $urandom_range(4000, 60000));
        endcase
        write_reg(REG_START_WITH_HEADERS, 32'($urandom_range(0, 1)));
      end
    end
    calm = 1'b0;

    how = finish_kind_t'($urandom_range(0, 5));
    case (how)
      END_TRAILER: begin
        send_size_line(32'd0);
        repeat ($urandom_range(0, 3)) begin
          send_item(any_but(CH_CR), 1'b0);
          // a lone CR or a bare LF is plain line content here
          repeat ($urandom_range(0, 5))
            send_item(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? CH_CR : CH_LF)
                                                  : 8'($urandom), 1'b0);
          send_item(CH_CR, 1'b0);
          send_item(CH_LF, 1'b0);
        end
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end
      END_CLOSE_LATE: begin
        case ($urandom_range(0, 2))
          0: begin
            send_size_line(32'd4);
            repeat (2) send_item(8'($urandom), 1'b0);
          end
          1: begin
            send_size_line(32'd2);
            repeat (2) send_item(8'($urandom), 1'b0);
            if ($urandom_range(0, 1)) send_item(CH_CR, 1'b0);
          end
          default: begin
            send_size_line(32'd0);
            repeat ($urandom_range(0, 3)) send_item(any_but(CH_CR), 1'b0);
          end
        endcase
        send_item(8'($urandom), 1'b1);
      end
      END_BAD_SIZE: begin
        case ($urandom_range(0, 5))
          0: begin
            // no digit on the line
            if ($urandom_range(0, 1)) send_item(CH_SPACE, 1'b0);
            send_item(CH_CR, 1'b0);
            send_item(CH_LF, 1'b0);
          end
          1: begin
            send_item("1", 1'b0);
            send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
            send_item("2", 1'b0);
          end
          2: begin
            send_item("1", 1'b0);
            do spare = $urandom_range(0, 255);
            while (hex_digit(8'(spare)) >= 0 || spare == CH_SPACE || spare == CH_TAB ||
                   spare == CH_SEMI || spare == CH_CR);
            send_item(8'(spare), 1'b0);
          end
          3: begin
            send_item("1", 1'b0);
            send_item(CH_CR, 1'b0);
            send_item(any_but(CH_LF), 1'b0);
          end
          4: begin
            send_item("1", 1'b0);
            send_item(CH_LF, 1'b0);
          end
          default: begin
            // nine significant digits overflow the counter
            repeat (9) send_item(hex_char(4'($urandom_range(1, 15)), $urandom_range(0, 1)), 1'b0);
          end
        endcase
      end
      END_NO_CRLF: begin
        spare = $urandom_range(1, 4);
        send_size_line(spare);
        repeat (spare) send_item(8'($urandom), 1'b0);
        if ($urandom_range(0, 1)) begin
          send_item(any_but(CH_CR), 1'b0);
        end else begin
          send_item(CH_CR, 1'b0);
          send_item(any_but(CH_LF), 1'b0);
        end
      end
      END_LIMIT: begin
        drain();
        spare = $urandom_range(0, 3);
        write_reg(REG_MAX_BODY_BYTES, emitted + spare);
        send_chunk(spare + $urandom_range(1, 4));
      end
      default: begin
        if ($urandom_range(0, 1)) send_item(CH_TAB, 1'b0);
        if ($urandom_range(0, 1)) send_item("7", 1'b0);
        send_item(8'($urandom), 1'b1);
      end
    endcase

    // everything after the end of the body is ignored
    repeat (16) send_item(8'($urandom), 1'($urandom));
    drain();

    if (mismatches == 0 && awaited_out.size() == 0)
      $display("PASS http_chunked_body_decoder_unit");
    else
      $display("FAIL http_chunked_body_decoder_unit");
    $finish;
  end

endmodule

/* filelist.f */
src/hcbd_pkg.sv
src/hcbd_step.sv
src/hcbd_out_buf.sv
src/http_chunked_body_decoder_unit.sv
tb/tb.sv
